// ===== sv/assert_macros.svh =====
// Assertion shorthands shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Overlapping implication, checked on every rising clock edge outside reset.
`define AST_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define AST_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/gibm_pkg.sv =====
// ----------------------------------------------------------------------------
// gibm_pkg
// Types and constants of the greedy IoU box matcher.
// ----------------------------------------------------------------------------
package gibm_pkg;

    localparam int unsigned MaxResults = 32;
    localparam logic [15:0] ThrReset   = 16'd13107;
    localparam int unsigned QuotBits   = 17;

    typedef enum logic [1:0] {
        OP_LOAD_TRACK = 2'd0,
        OP_LOAD_DET   = 2'd1,
        OP_RUN        = 2'd2,
        OP_CLEAR      = 2'd3
    } t_op;

    typedef struct packed {
        logic [1:0]         op;
        logic signed [15:0] box_left;
        logic signed [15:0] box_top;
        logic [14:0]        box_width;
        logic [14:0]        box_height;
    } t_cmd;

    typedef struct packed {
        logic signed [15:0] left;
        logic signed [15:0] top;
        logic [14:0]        width;
        logic [14:0]        height;
    } t_box;

    typedef struct packed {
        logic        pair_valid;
        logic [4:0]  track_index;
        logic [4:0]  det_index;
        logic [16:0] pair_iou;
        logic        last;
    } t_res;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD,
        ST_EDGE,
        ST_MUL,
        ST_UNI,
        ST_DIV,
        ST_WR,
        ST_SCAN,
        ST_DRAIN,
        ST_DEC,
        ST_FLUSH
    } t_state;

endpackage

// ===== sv/gibm_ram.sv =====
// ----------------------------------------------------------------------------
// gibm_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module gibm_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16,
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/gibm_div.sv =====
// ----------------------------------------------------------------------------
// gibm_div
// Restoring divider: floor(num * 2^16 / den), one quotient bit per cycle.
// ----------------------------------------------------------------------------
module gibm_div import gibm_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [29:0] i_num,
    input  logic [30:0] i_den,
    output logic        o_done,
    output logic [16:0] o_quot
);

    logic [31:0] r_rem;
    logic [30:0] r_den;
    logic [16:0] r_quot;
    logic [4:0]  r_cnt;
    logic        r_first;
    logic        r_busy;
    logic        r_done;
    logic        r_zero;
    logic [31:0] w_trial;
    logic        w_ge;

    // first step compares the numerator itself, later steps shift in a zero
    assign w_trial = r_first ? r_rem : {r_rem[30:0], 1'b0};
    assign w_ge    = w_trial >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == 5'd1) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
        if (i_start) begin
            r_rem   <= {2'b00, i_num};
            r_den   <= i_den;
            r_zero  <= i_den == 31'd0;
            r_cnt   <= 5'(QuotBits);
            r_first <= 1'b1;
        end else if (r_busy) begin
            r_rem   <= w_ge ? w_trial - {1'b0, r_den} : w_trial;
            r_quot  <= {r_quot[15:0], w_ge};
            r_cnt   <= r_cnt - 5'd1;
            r_first <= 1'b0;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_zero ? 17'd0 : r_quot;

    `include "assert_macros.svh"

    `AST_NXT(a_div_done, i_clk, i_rst_n, r_busy && r_cnt == 5'd1 && !i_start, r_done, "divider missed done")
    `AST_IMP(a_div_busy, i_clk, i_rst_n, r_busy, r_cnt != 5'd0, "divider ran past its count")

endmodule

// ===== sv/greedy_iou_box_matcher.sv =====
// ----------------------------------------------------------------------------
// greedy_iou_box_matcher
// Loads track and detection boxes and matches them greedily by IoU.
// ----------------------------------------------------------------------------
// Load, clear and run commands enter through start/busy. A load or clear
// leaves busy low. A run first computes the IoU of every stored pair, one pair
// at a time through a shared 15x15 multiplier (three products) and a one bit
// per cycle divider, and writes it into the overlap RAM. It then scans that
// RAM once per greedy round, one entry per cycle, and picks the largest IoU
// above the threshold register among untaken tracks and detections; ties go
// to the lower track, then the lower detection index. Matched pairs come out
// in greedy order, one strobe cycle each on o_res_valid, and the final one
// carries last. A run with no match gives one item with pair_valid low and
// last high. Results cannot be held off, so consume them as they appear.
// busy stays high for the whole run; at most 32 pairs are reported.
// ----------------------------------------------------------------------------
module greedy_iou_box_matcher import gibm_pkg::*; #(
    parameter int unsigned MAX_TRACKS = 32,
    parameter int unsigned MAX_DETS   = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  t_cmd        i_cmd,
    output logic        o_res_valid,
    output t_res        o_res,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int unsigned TW  = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1;
    localparam int unsigned DW  = (MAX_DETS > 1) ? $clog2(MAX_DETS) : 1;
    localparam int unsigned TFW = $clog2(MAX_TRACKS + 1);
    localparam int unsigned DFW = $clog2(MAX_DETS + 1);
    localparam int unsigned OVD = 1 << (TW + DW);

    // configuration
    logic [15:0] r_thr;

    // fill counts and run state
    logic [TFW-1:0] r_tfill;
    logic [DFW-1:0] r_dfill;
    t_state         r_state, n_state;
    logic [TW-1:0]  r_ti, r_si, r_pi, r_bi;
    logic [DW-1:0]  r_dj, r_sj, r_pj, r_bj;
    logic           r_pv;
    logic [1:0]     r_mcnt;
    logic [14:0]    r_ovx, r_ovy, r_tw, r_th, r_dw, r_dh;
    logic [29:0]    r_inter, r_area_t, r_area_d;
    logic           r_found;
    logic [16:0]    r_best;
    logic [MAX_TRACKS-1:0] r_ttaken;
    logic [MAX_DETS-1:0]   r_dtaken;
    logic           r_pend;
    t_res           r_pend_res;
    logic [5:0]     r_nf;
    logic           r_ostb;
    t_res           r_out;

    // memories and shared units
    t_box        w_trk, w_det;
    logic [16:0] w_ov_rd;
    logic        w_div_done;
    logic [16:0] w_quot;
    logic [29:0] w_prod;
    logic [14:0] w_ma, w_mb;
    logic [30:0] w_uni;
    logic signed [16:0] w_xlo, w_xhi, w_ylo, w_yhi, w_ta1, w_da1, w_tb1, w_db1;
    logic signed [16:0] w_xd, w_yd;

    // control strobes
    logic w_accept, w_trk_we, w_det_we, w_ov_we, w_div_start;
    logic w_pair_last, w_scan_last, w_cand;

    assign w_accept = start && !busy;

    // ---------------- configuration port ----------------
    assign pready = 1'b1;
    assign prdata = paddr[2] ? 32'd0 : {16'd0, r_thr};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= ThrReset;
        end else if (psel && penable && pwrite && !paddr[2]) begin
            r_thr <= pwdata[15:0];
        end
    end

    // ---------------- stores ----------------
    gibm_ram #(.WIDTH($bits(t_box)), .DEPTH(MAX_TRACKS)) u_trk (
        .i_clk   (i_clk),
        .i_we    (w_trk_we),
        .i_waddr (r_tfill[TW-1:0]),
        .i_wdata ({i_cmd.box_left, i_cmd.box_top, i_cmd.box_width, i_cmd.box_height}),
        .i_raddr (r_ti),
        .o_rdata (w_trk)
    );

    gibm_ram #(.WIDTH($bits(t_box)), .DEPTH(MAX_DETS)) u_det (
        .i_clk   (i_clk),
        .i_we    (w_det_we),
        .i_waddr (r_dfill[DW-1:0]),
        .i_wdata ({i_cmd.box_left, i_cmd.box_top, i_cmd.box_width, i_cmd.box_height}),
        .i_raddr (r_dj),
        .o_rdata (w_det)
    );

    gibm_ram #(.WIDTH(17), .DEPTH(OVD)) u_ov (
        .i_clk   (i_clk),
        .i_we    (w_ov_we),
        .i_waddr ({r_ti, r_dj}),
        .i_wdata (w_quot),
        .i_raddr ({r_si, r_sj}),
        .o_rdata (w_ov_rd)
    );

    gibm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (r_inter),
        .i_den   (w_uni),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    // ---------------- pair arithmetic ----------------
    // edges: right = left + width, exact in 17 bits
    assign w_ta1 = {w_trk.left[15], w_trk.left} + $signed({2'b00, w_trk.width});
    assign w_da1 = {w_det.left[15], w_det.left} + $signed({2'b00, w_det.width});
    assign w_tb1 = {w_trk.top[15], w_trk.top} + $signed({2'b00, w_trk.height});
    assign w_db1 = {w_det.top[15], w_det.top} + $signed({2'b00, w_det.height});
    assign w_xlo = (w_trk.left > w_det.left) ? 17'(w_trk.left) : 17'(w_det.left);
    assign w_ylo = (w_trk.top > w_det.top) ? 17'(w_trk.top) : 17'(w_det.top);
    assign w_xhi = (w_ta1 < w_da1) ? w_ta1 : w_da1;
    assign w_yhi = (w_tb1 < w_db1) ? w_tb1 : w_db1;
    assign w_xd  = w_xhi - w_xlo;
    assign w_yd  = w_yhi - w_ylo;

    // one multiplier: intersection, track area, detection area in turn
    always_comb begin
        unique case (r_mcnt)
            2'd0:    begin w_ma = r_ovx; w_mb = r_ovy; end
            2'd1:    begin w_ma = r_tw;  w_mb = r_th;  end
            default: begin w_ma = r_dw;  w_mb = r_dh;  end
        endcase
    end
    assign w_prod = w_ma * w_mb;
    assign w_uni  = {1'b0, r_area_t} + {1'b0, r_area_d} - {1'b0, r_inter};

    assign w_pair_last = (TFW'(r_ti) == r_tfill - TFW'(1)) && (DFW'(r_dj) == r_dfill - DFW'(1));
    assign w_scan_last = (TFW'(r_si) == r_tfill - TFW'(1)) && (DFW'(r_sj) == r_dfill - DFW'(1));
    assign w_cand = r_pv && !r_ttaken[r_pi] && !r_dtaken[r_pj]
                    && (w_ov_rd > {1'b0, r_thr}) && (!r_found || w_ov_rd > r_best);

    // ---------------- sequencer: next state ----------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept && i_cmd.op == OP_RUN) begin
                    if (r_tfill == '0 || r_dfill == '0) begin
                        n_state = ST_FLUSH;
                    end else begin
                        n_state = ST_RD;
                    end
                end
            end
            ST_RD:    n_state = ST_EDGE;
            ST_EDGE:  n_state = ST_MUL;
            ST_MUL:   n_state = (r_mcnt == 2'd2) ? ST_UNI : ST_MUL;
            ST_UNI:   n_state = ST_DIV;
            ST_DIV:   n_state = w_div_done ? ST_WR : ST_DIV;
            ST_WR:    n_state = w_pair_last ? ST_SCAN : ST_RD;
            ST_SCAN:  n_state = w_scan_last ? ST_DRAIN : ST_SCAN;
            ST_DRAIN: n_state = ST_DEC;
            ST_DEC: begin
                if (r_found && (7'(r_nf) + 7'd1 != 7'(MaxResults))) begin
                    n_state = ST_SCAN;
                end else begin
                    n_state = ST_FLUSH;
                end
            end
            ST_FLUSH: n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // ---------------- sequencer: control outputs ----------------
    always_comb begin
        w_trk_we    = 1'b0;
        w_det_we    = 1'b0;
        w_ov_we     = 1'b0;
        w_div_start = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                w_trk_we = w_accept && i_cmd.op == OP_LOAD_TRACK
                           && r_tfill != TFW'(MAX_TRACKS);
                w_det_we = w_accept && i_cmd.op == OP_LOAD_DET
                           && r_dfill != DFW'(MAX_DETS);
            end
            ST_UNI:  w_div_start = 1'b1;
            ST_WR:   w_ov_we = 1'b1;
            default: begin end
        endcase
    end

    assign busy = r_state != ST_IDLE;

    // ---------------- registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_tfill  <= '0;
            r_dfill  <= '0;
            r_ostb   <= 1'b0;
            r_pv     <= 1'b0;
            r_pend   <= 1'b0;
            r_found  <= 1'b0;
            r_nf     <= '0;
            r_ttaken <= '0;
            r_dtaken <= '0;
            r_mcnt   <= '0;
        end else begin
            r_state <= n_state;
            // strobe on a held pair displaced by a new one, and on the flush
            r_ostb  <= (r_state == ST_FLUSH) || (r_state == ST_DEC && r_found && r_pend);
            // the entry addressed during a scan cycle is compared in the cycle after
            r_pv    <= r_state == ST_SCAN;
            unique case (r_state)
                ST_IDLE: begin
                    if (w_trk_we) r_tfill <= r_tfill + TFW'(1);
                    if (w_det_we) r_dfill <= r_dfill + DFW'(1);
                    if (w_accept && i_cmd.op == OP_CLEAR) begin
                        r_tfill <= '0;
                        r_dfill <= '0;
                    end
                    if (w_accept && i_cmd.op == OP_RUN) begin
                        r_ti     <= '0;
                        r_dj     <= '0;
                        r_si     <= '0;
                        r_sj     <= '0;
                        r_pend   <= 1'b0;
                        r_nf     <= '0;
                        r_ttaken <= '0;
                        r_dtaken <= '0;
                    end
                end
                ST_EDGE: begin
                    // clamp each axis overlap at zero
                    r_ovx  <= (w_xhi > w_xlo) ? w_xd[14:0] : 15'd0;
                    r_ovy  <= (w_yhi > w_ylo) ? w_yd[14:0] : 15'd0;
                    r_tw   <= w_trk.width;
                    r_th   <= w_trk.height;
                    r_dw   <= w_det.width;
                    r_dh   <= w_det.height;
                    r_mcnt <= 2'd0;
                end
                ST_MUL: begin
                    unique case (r_mcnt)
                        2'd0:    r_inter  <= w_prod;
                        2'd1:    r_area_t <= w_prod;
                        default: r_area_d <= w_prod;
                    endcase
                    r_mcnt <= r_mcnt + 2'd1;
                end
                ST_WR: begin
                    // advance to the next pair, detections inner
                    if (DFW'(r_dj) == r_dfill - DFW'(1)) begin
                        r_dj <= '0;
                        if (!w_pair_last) r_ti <= r_ti + TW'(1);
                    end else begin
                        r_dj <= r_dj + DW'(1);
                    end
                end
                ST_SCAN: begin
                    r_pi <= r_si;
                    r_pj <= r_sj;
                    if (DFW'(r_sj) == r_dfill - DFW'(1)) begin
                        r_sj <= '0;
                        r_si <= r_si + TW'(1);
                    end else begin
                        r_sj <= r_sj + DW'(1);
                    end
                end
                ST_DEC: begin
                    r_si    <= '0;
                    r_sj    <= '0;
                    if (r_found) begin
                        // hold the new pair until the next round shows if it is last
                        r_ttaken[r_bi] <= 1'b1;
                        r_dtaken[r_bj] <= 1'b1;
                        r_nf           <= r_nf + 6'd1;
                        if (r_pend) begin
                            r_out  <= r_pend_res;
                        end
                        r_pend                 <= 1'b1;
                        r_pend_res.pair_valid  <= 1'b1;
                        r_pend_res.track_index <= 5'(r_bi);
                        r_pend_res.det_index   <= 5'(r_bj);
                        r_pend_res.pair_iou    <= r_best;
                        r_pend_res.last        <= 1'b0;
                    end
                end
                ST_FLUSH: begin
                    if (r_pend) begin
                        r_out <= '{pair_valid: r_pend_res.pair_valid,
                                   track_index: r_pend_res.track_index,
                                   det_index: r_pend_res.det_index,
                                   pair_iou: r_pend_res.pair_iou, last: 1'b1};
                    end else begin
                        r_out <= '{pair_valid: 1'b0, track_index: 5'd0, det_index: 5'd0,
                                   pair_iou: 17'd0, last: 1'b1};
                    end
                    r_pend <= 1'b0;
                end
                default: begin end
            endcase
            // compare the entry read last cycle; drop the best at a round start
            if (w_cand) begin
                r_found <= 1'b1;
                r_best  <= w_ov_rd;
                r_bi    <= r_pi;
                r_bj    <= r_pj;
            end else if ((r_state == ST_IDLE && w_accept && i_cmd.op == OP_RUN)
                         || r_state == ST_DEC) begin
                r_found <= 1'b0;
            end
        end
    end

    assign o_res_valid = r_ostb;
    assign o_res       = r_out;

    `include "assert_macros.svh"

    `AST_NXT(a_last_ends, i_clk, i_rst_n, o_res_valid && o_res.last, !o_res_valid, "item after last")
    `AST_IMP(a_empty_last, i_clk, i_rst_n, o_res_valid && !o_res.pair_valid, o_res.last, "empty item without last")
    `AST_NXT(a_run_busy, i_clk, i_rst_n, w_accept && i_cmd.op == OP_RUN, busy, "run did not start")
    `AST_IMP(a_fill_cap, i_clk, i_rst_n, 1'b1, r_tfill <= TFW'(MAX_TRACKS) && r_dfill <= DFW'(MAX_DETS), "fill count over capacity")

endmodule

// ===== sim/greedy_iou_box_matcher_test.sv =====
// ----------------------------------------------------------------------------
// greedy_iou_box_matcher_test
// Self-checking bench for the greedy IoU box matcher.
// ----------------------------------------------------------------------------
// A short table of directed commands (empty run, identical boxes, disjoint
// extreme boxes, zero-area boxes, ties) is followed by random load/run
// sequences at several IoU thresholds and sender idle rates. Each accepted
// command goes through a behavioral model of the matcher; every result strobe
// is compared field by field with the oldest pending expectation.
// ----------------------------------------------------------------------------
module greedy_iou_box_matcher_test import gibm_pkg::*; ();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NumSlots   = 32;
    localparam int StallLimit = 300000;   // long enough for a full 32x32 run
    localparam int DrainWait  = 40;

    typedef struct {
        t_cmd cmd;
        bit   fixed;     // expectation typed in below instead of predicted
        t_res res;
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    t_cmd        i_cmd;
    logic        o_res_valid;
    t_res        o_res;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    greedy_iou_box_matcher uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_cmd       (i_cmd),
        .o_res_valid (o_res_valid),
        .o_res       (o_res),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // Matcher state as the bench sees it.
    t_box        trk_boxes [NumSlots];
    t_box        det_boxes [NumSlots];
    int          trk_count;
    int          det_count;
    logic [15:0] match_thr;

    t_res pair_q[$];   // expected results, oldest first
    int   mismatches;
    int   stall_cycles;

    // IoU in Q1.16 rounded down, zero for an empty union.
    function automatic longint box_iou(t_box a, t_box b);
        longint al, at, aw, ah, bl, bt, bw, bh, ox, oy, lo, hi, inter, uni;
        al = a.left;  at = a.top;  aw = a.width; ah = a.height;
        bl = b.left;  bt = b.top;  bw = b.width; bh = b.height;
        lo = (al > bl) ? al : bl;
        hi = (al + aw < bl + bw) ? al + aw : bl + bw;
        ox = (hi > lo) ? hi - lo : 0;
        lo = (at > bt) ? at : bt;
        hi = (at + ah < bt + bh) ? at + ah : bt + bh;
        oy = (hi > lo) ? hi - lo : 0;
        inter = ox * oy;
        uni = aw * ah + bw * bh - inter;
        if (uni == 0) return 0;
        return (inter * 65536) / uni;
    endfunction

    // Advance the model by one command and return the results it causes.
    task automatic predict_cmd(input t_cmd c, ref t_res outs[$]);
        t_box   b;
        longint ovl [NumSlots][NumSlots];
        bit     trk_used [NumSlots];
        bit     det_used [NumSlots];
        longint best;
        int     bi, bj;
        bit     found;
        t_res   r;
        b.left = c.box_left;
        b.top = c.box_top;
        b.width = c.box_width;
        b.height = c.box_height;
        outs = {};
        case (t_op'(c.op))
            OP_LOAD_TRACK: if (trk_count < NumSlots) begin
                trk_boxes[trk_count] = b;
                trk_count++;
            end
            OP_LOAD_DET: if (det_count < NumSlots) begin
                det_boxes[det_count] = b;
                det_count++;
            end
            OP_CLEAR: begin
                trk_count = 0;
                det_count = 0;
            end
            default: begin
                for (int i = 0; i < trk_count; i++) begin
                    trk_used[i] = 0;
                    for (int j = 0; j < det_count; j++)
                        ovl[i][j] = box_iou(trk_boxes[i], det_boxes[j]);
                end
                for (int j = 0; j < det_count; j++) det_used[j] = 0;
                while (outs.size() < MaxResults) begin
                    found = 0;
                    best = 0;
                    bi = 0;
                    bj = 0;
                    // Strict compare in scan order keeps the lowest indices on ties.
                    for (int i = 0; i < trk_count; i++) begin
                        if (trk_used[i]) continue;
                        for (int j = 0; j < det_count; j++) begin
                            if (det_used[j]) continue;
                            if (ovl[i][j] > match_thr && (!found || ovl[i][j] > best)) begin
                                found = 1;
                                best = ovl[i][j];
                                bi = i;
                                bj = j;
                            end
                        end
                    end
                    if (!found) break;
                    trk_used[bi] = 1;
                    det_used[bj] = 1;
                    r.pair_valid = 1'b1;
                    r.track_index = bi[4:0];
                    r.det_index = bj[4:0];
                    r.pair_iou = best[16:0];
                    r.last = 1'b0;
                    outs = {outs, r};
                end
                if (outs.size() == 0) begin
                    r = '0;
                    r.last = 1'b1;
                    outs = {outs, r};
                end else begin
                    outs[outs.size() - 1].last = 1'b1;
                end
            end
        endcase
    endtask

    // Hold the command until accepted, then queue its results and maybe idle.
    task automatic issue(input t_cmd c, input bit fixed, input t_res typed, input int idle_pct);
        t_res outs[$];
        i_cmd <= c;
        start <= 1'b1;
        do @(posedge i_clk); while (busy !== 1'b0);
        predict_cmd(c, outs);
        if (fixed) outs = '{typed};
        foreach (outs[k]) pair_q = {pair_q, outs[k]};
        if ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
    endtask

    function automatic t_cmd make_cmd(t_op op, t_box b);
        t_cmd c;
        c.op = op;
        c.box_left = b.left;
        c.box_top = b.top;
        c.box_width = b.width;
        c.box_height = b.height;
        return c;
    endfunction

    function automatic t_box rand_box();
        t_box b;
        if ($urandom_range(7) == 0) begin
            b.left = 16'($urandom);
            b.top = 16'($urandom);
            b.width = 15'($urandom);
            b.height = 15'($urandom);
        end else begin
            b.left = 16'(int'($urandom_range(400)) - 200);
            b.top = 16'(int'($urandom_range(400)) - 200);
            b.width = 15'($urandom_range(60));
            b.height = 15'($urandom_range(60));
        end
        return b;
    endfunction

    // Drain all pending results, let the block settle, then program the threshold and read it back.
    task automatic set_threshold(input logic [15:0] thr);
        start <= 1'b0;
        while (pair_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        while (busy !== 1'b0) @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= 3'd0;
        pwdata <= {16'h0, thr};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        match_thr = thr;
        // Read back through the same port.
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (prdata[15:0] !== thr) begin
            mismatches++;
            if (mismatches <= 10)
                $display("threshold readback: expected %0d got %0d", thr, prdata[15:0]);
        end
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    // Optional overfill run, then mostly clear/load/run sequences with related boxes, some loose noise.
    task automatic random_block(input int n_items, input int idle_pct, input bit with_overflow);
        int    sent;
        int    nt, nd;
        t_box  trk_local [$];
        t_box  b;
        t_res  none;
        sent = 0;
        none = '0;
        if (with_overflow) begin
            // Overfill both sets; the extra loads must be dropped.
            issue(make_cmd(OP_CLEAR, rand_box()), 0, none, idle_pct);
            for (int k = 0; k < NumSlots + 2; k++) begin
                b = rand_box();
                issue(make_cmd(OP_LOAD_TRACK, b), 0, none, idle_pct);
                b.left = b.left + 16'($urandom_range(4)) - 16'sd2;
                issue(make_cmd(OP_LOAD_DET, b), 0, none, idle_pct);
            end
            issue(make_cmd(OP_RUN, rand_box()), 0, none, idle_pct);
            sent += 2 * NumSlots + 6;
        end
        while (sent < n_items) begin
            if ($urandom_range(4) == 0) begin
                issue(make_cmd(t_op'($urandom_range(3)), rand_box()), 0, none, idle_pct);
                sent++;
            end else begin
                if ($urandom_range(4) != 0) begin
                    issue(make_cmd(OP_CLEAR, rand_box()), 0, none, idle_pct);
                    sent++;
                end
                nt = $urandom_range(1, 6);
                nd = $urandom_range(1, 6);
                trk_local = {};
                for (int k = 0; k < nt; k++) begin
                    b = rand_box();
                    trk_local = {trk_local, b};
                    issue(make_cmd(OP_LOAD_TRACK, b), 0, none, idle_pct);
                end
                for (int k = 0; k < nd; k++) begin
                    b = trk_local[$urandom_range(nt - 1)];
                    case ($urandom_range(3))
                        0: ;    // exact copy, IoU of one unless the box is empty
                        1: begin
                            b.left = b.left + 16'($urandom_range(10)) - 16'sd5;
                            b.top = b.top + 16'($urandom_range(10)) - 16'sd5;
                            b.width = b.width + 15'($urandom_range(4));
                        end
                        2: b.left = b.left + 16'($urandom_range(20));
                        default: b = rand_box();
                    endcase
                    issue(make_cmd(OP_LOAD_DET, b), 0, none, idle_pct);
                end
                issue(make_cmd(OP_RUN, rand_box()), 0, none, idle_pct);
                sent += nt + nd + 1;
            end
        end
    endtask

    // Check each result strobe against the oldest expectation; watch for stalls.
    always @(posedge i_clk) begin
        t_res want;
        if (i_rst_n) begin
            if (o_res_valid === 1'b1) begin
                if (pair_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected result %p", o_res);
                end else begin
                    want = pair_q.pop_front();
                    if (o_res.pair_valid !== want.pair_valid
                        || o_res.track_index !== want.track_index
                        || o_res.det_index !== want.det_index
                        || o_res.pair_iou !== want.pair_iou
                        || o_res.last !== want.last) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("result mismatch: expected %p got %p", want, o_res);
                    end
                end
            end
            if ((start === 1'b1 && busy === 1'b0) || o_res_valid === 1'b1)
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= StallLimit) begin
                $display("FAIL");
                $finish;
            end
        end
    end

    initial begin
        t_row rows [$];
        t_row row;
        t_box b;
        int   thr_pick;

        i_rst_n <= 1'b0;
        start <= 1'b0;
        i_cmd <= '0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        mismatches = 0;
        stall_cycles = 0;
        trk_count = 0;
        det_count = 0;
        match_thr = ThrReset;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table: {op, left, top, width, height}, fixed flag, typed result.
        rows = '{
            '{t_cmd'{OP_RUN, 16'sd0, 16'sd0, 15'd0, 15'd0}, 1, t_res'{1'b0, 5'd0, 5'd0, 17'd0, 1'b1}},
            '{t_cmd'{OP_LOAD_TRACK, 16'sd0, 16'sd0, 15'd10, 15'd10}, 0, t_res'('0)},
            '{t_cmd'{OP_LOAD_DET, 16'sd0, 16'sd0, 15'd10, 15'd10}, 0, t_res'('0)},
            '{t_cmd'{OP_RUN, 16'sd0, 16'sd0, 15'd0, 15'd0}, 1,
              t_res'{1'b1, 5'd0, 5'd0, 17'd65536, 1'b1}},
            '{t_cmd'{OP_CLEAR, 16'sd0, 16'sd0, 15'd0, 15'd0}, 0, t_res'('0)},
            '{t_cmd'{OP_LOAD_TRACK, -16'sd32768, -16'sd32768, 15'd32767, 15'd32767}, 0,
              t_res'('0)},
            '{t_cmd'{OP_LOAD_DET, 16'sd32767, 16'sd32767, 15'd32767, 15'd32767}, 0,
              t_res'('0)},
            '{t_cmd'{OP_RUN, 16'sd0, 16'sd0, 15'd0, 15'd0}, 1, t_res'{1'b0, 5'd0, 5'd0, 17'd0, 1'b1}},
            '{t_cmd'{OP_CLEAR, -16'sd1, -16'sd1, 15'd32767, 15'd32767}, 0, t_res'('0)},
            '{t_cmd'{OP_LOAD_TRACK, 16'sd5, 16'sd5, 15'd0, 15'd0}, 0, t_res'('0)},
            '{t_cmd'{OP_LOAD_DET, 16'sd5, 16'sd5, 15'd0, 15'd0}, 0, t_res'('0)},
            '{t_cmd'{OP_RUN, 16'sd0, 16'sd0, 15'd0, 15'd0}, 1, t_res'{1'b0, 5'd0, 5'd0, 17'd0, 1'b1}},
            '{t_cmd'{OP_CLEAR, 16'sd0, 16'sd0, 15'd0, 15'd0}, 0, t_res'('0)},
            '{t_cmd'{OP_LOAD_TRACK, 16'sd0, 16'sd0, 15'd10, 15'd10}, 0, t_res'('0)},
            '{t_cmd'{OP_LOAD_TRACK, 16'sd100, 16'sd100, 15'd10, 15'd10}, 0, t_res'('0)},
            '{t_cmd'{OP_LOAD_DET, 16'sd100, 16'sd100, 15'd10, 15'd10}, 0, t_res'('0)},
            '{t_cmd'{OP_LOAD_DET, 16'sd0, 16'sd0, 15'd10, 15'd10}, 0, t_res'('0)},
            '{t_cmd'{OP_LOAD_DET, 16'sd2, 16'sd0, 15'd10, 15'd10}, 0, t_res'('0)},
            '{t_cmd'{OP_RUN, 16'sd0, 16'sd0, 15'd0, 15'd0}, 0, t_res'('0)},
            '{t_cmd'{OP_LOAD_TRACK, 16'sd32767, -16'sd32768, 15'd32767, 15'd1}, 0, t_res'('0)},
            '{t_cmd'{OP_LOAD_DET, 16'sd32760, -16'sd32768, 15'd32767, 15'd1}, 0, t_res'('0)},
            '{t_cmd'{OP_RUN, 16'sd0, 16'sd0, 15'd0, 15'd0}, 0, t_res'('0)}
        };
        foreach (rows[k]) begin
            row = rows[k];
            issue(row.cmd, row.fixed, row.res, 0);
        end

        // Random phases; each threshold change waits for the block to go quiet.
        set_threshold(16'd0);
        random_block(90, 35, 0);
        set_threshold(16'hFFFF);
        random_block(80, 86, 0);
        thr_pick = $urandom_range(1, 65534);
        set_threshold(thr_pick[15:0]);
        random_block(100, 0, 1);
        set_threshold(ThrReset);
        random_block(60, 0, 0);

        start <= 1'b0;
        while (pair_q.size() != 0) @(posedge i_clk);
        repeat (DrainWait) @(posedge i_clk);
        if (mismatches == 0 && pair_q.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ===== greedy_iou_box_matcher.f =====
+incdir+sv
sv/gibm_pkg.sv
sv/gibm_ram.sv
sv/gibm_div.sv
sv/greedy_iou_box_matcher.sv
sim/greedy_iou_box_matcher_test.sv
